/* rtl/core/hue_change_motion_detector_macros.svh */
`ifndef HUE_CHANGE_MOTION_DETECTOR_MACROS_SVH
`define HUE_CHANGE_MOTION_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HCMD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HCMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/hcmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hcmd_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int PIX_W       = 8;
    localparam int NUM_W       = 14;
    localparam int DIV_STEPS   = NUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int FRAME_W     = 24;
    localparam int IN_DATA_W   = 6 * PIX_W;
    localparam int OUT_COUNT_W = 24;
    localparam int OUT_DATA_W  = 32;
    localparam int MOT_W       = COUNT_WIDTH + 7;
    localparam int HUE_SCALE   = 43;
    localparam int MOTION_SCALE = 100;

    localparam logic [FRAME_W-1:0]     FRAME_PIXELS_RESET = FRAME_W'(307200);
    localparam logic [PIX_W-1:0]       HUE_THRESHOLD      = PIX_W'(16);
    localparam logic [PIX_W-1:0]       BASE_RED           = PIX_W'(0);
    localparam logic [PIX_W-1:0]       BASE_GREEN         = PIX_W'(85);
    localparam logic [PIX_W-1:0]       BASE_BLUE          = PIX_W'(171);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX          = '1;
    localparam logic [DIV_CNT_W-1:0]   DIV_LAST           = DIV_CNT_W'(DIV_STEPS - 1);

    // Everything the back end needs to finish the hue of one color.
    typedef struct packed {
        logic             zero;
        logic             neg;
        logic [NUM_W-1:0] num_mag;
        logic [PIX_W-1:0] span;
        logic [PIX_W-1:0] base;
    } t_chan;

    typedef struct packed {
        t_chan prev;
        t_chan cur;
        logic  sel;
        logic  last;
    } t_q_entry;

    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [NUM_W-1:0] quo;
    } t_div;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HUE,
        ST_EMIT
    } t_back_state;

    function automatic t_chan classify(input logic [PIX_W-1:0] r,
                                       input logic [PIX_W-1:0] g,
                                       input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] mn;
        logic [PIX_W:0]   diff;
        logic [PIX_W-1:0] mag;
        t_chan            c;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        // Ties on the largest channel go to red first, then green.
        if (mx == r) begin
            c.base = BASE_RED;
            diff   = {1'b0, g} - {1'b0, b};
        end else if (mx == g) begin
            c.base = BASE_GREEN;
            diff   = {1'b0, b} - {1'b0, r};
        end else begin
            c.base = BASE_BLUE;
            diff   = {1'b0, r} - {1'b0, g};
        end
        c.neg     = diff[PIX_W];
        mag       = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];
        c.num_mag = NUM_W'(mag) * NUM_W'(HUE_SCALE);
        c.span    = mx - mn;
        c.zero    = (mx == mn);
        return c;
    endfunction

    // One restoring division step: one quotient bit.
    function automatic t_div div_step(input t_div s, input logic [PIX_W-1:0] span);
        logic [PIX_W:0] trial;
        t_div           n;
        trial = {s.rem, s.quo[NUM_W-1]};
        n.quo = {s.quo[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, span}) begin
            n.rem    = PIX_W'(trial - {1'b0, span});
            n.quo[0] = 1'b1;
        end else begin
            n.rem = trial[PIX_W-1:0];
        end
        return n;
    endfunction

    // Quotient magnitude is truncated toward zero, so the sign is applied after.
    function automatic logic [PIX_W-1:0] hue_of(input t_chan c, input logic [NUM_W-1:0] q);
        logic [PIX_W-1:0] q8;
        q8 = q[PIX_W-1:0];
        if (c.zero) begin
            return '0;
        end
        return c.neg ? (c.base - q8) : (c.base + q8);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hcmd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module hcmd_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire hcmd_pkg::t_q_entry i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output hcmd_pkg::t_q_entry      o_data,
    output logic                    o_empty
);
    import hcmd_pkg::*;

    t_q_entry           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/hcmd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module hcmd_front (
    input  wire logic [hcmd_pkg::IN_DATA_W-1:0] i_tdata,
    input  wire logic                           i_tuser,
    input  wire logic                           i_tlast,
    input  wire logic                           i_tvalid,
    output logic                                o_tready,
    input  wire logic                           i_full,
    output logic                                o_push,
    output hcmd_pkg::t_q_entry                  o_entry
);
    import hcmd_pkg::*;

    // Both colors are reduced to sign, magnitude, span and base here, so the
    // back end only has to divide.
    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    always_comb begin
        o_entry.prev = classify(i_tdata[0*PIX_W +: PIX_W], i_tdata[1*PIX_W +: PIX_W],
                                i_tdata[2*PIX_W +: PIX_W]);
        o_entry.cur  = classify(i_tdata[3*PIX_W +: PIX_W], i_tdata[4*PIX_W +: PIX_W],
                                i_tdata[5*PIX_W +: PIX_W]);
        o_entry.sel  = i_tuser;
        o_entry.last = i_tlast;
    end

endmodule

`default_nettype wire

/* rtl/core/hcmd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "hue_change_motion_detector_macros.svh"

module hcmd_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [hcmd_pkg::FRAME_W-1:0]     i_frame_pixels,
    input  wire logic                             i_empty,
    input  wire hcmd_pkg::t_q_entry               i_entry,
    output logic                                  o_pop,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [hcmd_pkg::OUT_DATA_W-1:0]       o_m_tdata
);
    import hcmd_pkg::*;

    t_back_state            r_state, n_state;
    t_q_entry               r_ent;
    t_div                   r_div_p, r_div_c;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_m_valid;
    logic                   r_m_motion;
    logic [OUT_COUNT_W-1:0] r_m_changed;

    logic                   emit;
    logic                   count_up;
    logic [PIX_W-1:0]       hue_p, hue_c, hue_d;
    logic                   motion;

    assign hue_p  = hue_of(r_ent.prev, r_div_p.quo);
    assign hue_c  = hue_of(r_ent.cur, r_div_c.quo);
    assign hue_d  = (hue_c > hue_p) ? (hue_c - hue_p) : (hue_p - hue_c);
    assign motion = (MOT_W'(r_count) * MOT_W'(MOTION_SCALE)) > MOT_W'(i_frame_pixels);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_div_cnt == DIV_LAST) n_state = ST_HUE;
            end
            ST_HUE: begin
                n_state = r_ent.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!r_m_valid || i_m_tready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        emit     = 1'b0;
        count_up = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = !i_empty;
            end
            ST_HUE: begin
                count_up = r_ent.sel && (hue_d > HUE_THRESHOLD) && (r_count != COUNT_MAX);
            end
            ST_EMIT: begin
                emit = !r_m_valid || i_m_tready;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_div_cnt <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_div_cnt <= '0;
            end else if (r_state == ST_DIV) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (emit) begin
                r_count <= '0;
            end else if (count_up) begin
                r_count <= r_count + 1'b1;
            end
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent       <= i_entry;
            r_div_p.rem <= '0;
            r_div_p.quo <= i_entry.prev.num_mag;
            r_div_c.rem <= '0;
            r_div_c.quo <= i_entry.cur.num_mag;
        end else if (r_state == ST_DIV) begin
            r_div_p <= div_step(r_div_p, r_ent.prev.span);
            r_div_c <= div_step(r_div_c, r_ent.cur.span);
        end
        if (emit) begin
            r_m_motion  <= motion;
            r_m_changed <= OUT_COUNT_W'(r_count);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_m_changed, r_m_motion});

    `HCMD_ASSERT_NEXT(a_count_sat, (r_state != ST_EMIT) && (r_count == COUNT_MAX),
        r_count == COUNT_MAX, "count left saturation outside frame end")
    `HCMD_ASSERT_IMP(a_div_range, r_state == ST_DIV, r_div_cnt <= DIV_LAST,
        "divide step counter overran")
    `HCMD_ASSERT_NEXT(a_emit_clear, emit, r_m_valid && (r_count == '0),
        "frame end did not load result and clear count")
    `HCMD_ASSERT_IMP(a_result_src, $rose(r_m_valid), $past(r_state == ST_EMIT),
        "result appeared without frame end")

endmodule

`default_nettype wire

/* rtl/core/hue_change_motion_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// Hue-change motion detector.
// Input stream (s_axis): one request per pixel pair. tdata carries the previous and current
// RGB bytes, tuser the selection bit and tlast the end-of-frame mark. Each request yields
// an 8-bit hue for both colors; a selected pixel whose two hues differ by more than 16
// bumps a saturating change counter.
// Output stream (m_axis): one request per frame, sent after the tlast pixel. It carries
// the change count and a motion flag that is set when count * 100 exceeds frame_pixels.
// Configuration: i_cfg_we writes frame_pixels from i_cfg_wdata at the next rising edge.
// Each pixel pair is popped, run through the back end's two restoring dividers, one per
// color, which make one quotient bit per cycle for 14 bits, and then hue compared; the
// last pixel of a frame adds a frame-end step. A pair is popped only after the last is done.
// A tlast result goes through the queue and the pop, divide, hue and emit states to m_axis.
// A two-entry queue between the classifier and the dividers lets s_axis run ahead.
// Reset (i_rst_n low, synchronous): queue emptied, counter cleared, output dropped, and
// frame_pixels returns to 307200.
// When the receiver stalls, the result holds in the output register; the back end waits
// at frame end only, and s_axis backs up once the queue fills.
module hue_change_motion_detector (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // [7:0] prev_red, [15:8] prev_green, [23:16] prev_blue,
    // [31:24] cur_red, [39:32] cur_green, [47:40] cur_blue
    input  wire logic [hcmd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] pixel_selected
    input  wire logic                             s_axis_tuser,
    input  wire logic                             s_axis_tlast,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [0] motion_detected, [24:1] changed_pixels, upper bits zero
    output logic [hcmd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic                             i_cfg_we,
    input  wire logic [hcmd_pkg::FRAME_W-1:0]     i_cfg_wdata
);
    import hcmd_pkg::*;

    logic [FRAME_W-1:0] r_frame_pixels;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    t_q_entry           q_in;
    t_q_entry           q_out;

    // The frame size only feeds the motion threshold compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FRAME_PIXELS_RESET;
        end else if (i_cfg_we) begin
            r_frame_pixels <= i_cfg_wdata;
        end
    end

    // Front end: accepts a request whenever the queue has room and classifies both colors.
    hcmd_front u_front (
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_tlast  (s_axis_tlast),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    hcmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // Back end: divides, compares hues, counts, and sends the per-frame result.
    hcmd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_pixels (r_frame_pixels),
        .i_empty        (q_empty),
        .i_entry        (q_out),
        .o_pop          (q_pop),
        .o_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .o_m_tdata      (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    // The block under test reads two RGB pixels per request, works out an 8-bit hue for
    // each, and counts selected pixels whose hues are more than HUE_LIMIT apart. One
    // report (count plus motion flag) leaves per frame, on the request marked tlast.
    localparam int          HUE_LIMIT     = 16;
    localparam int          MOTION_SCALE  = 100;
    localparam int          SHOWN_ERRORS  = 10;
    // The wait before a register write or the final verdict leaves margin over the block's
    // path from tlast to its report.
    localparam int          SETTLE_CYCLES = 40;
    localparam int          DRAIN_CYCLES  = 5000;
    localparam int          PHASE_ITEMS   = 139;
    localparam logic [23:0] TALLY_MAX     = '1;
    localparam logic [23:0] SIZE_AT_RESET = 24'd307200;

    // Channel order puts red in the lowest byte, matching the tdata layout.
    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgb_t;

    typedef struct packed {
        rgb_t cur;
        rgb_t prev;
        logic sel;
        logic last;
    } pair_t;

    // Same layout as the low 25 bits of m_axis_tdata.
    typedef struct packed {
        logic [23:0] count;
        logic        motion;
    } report_t;

    typedef enum {
        ROW_PIXEL,
        ROW_FRAME_SIZE
    } row_kind_t;

    // One line of the directed table: either a pixel request or a frame size write.
    // Where the report of a frame is obvious by hand, it is typed in and used as is.
    typedef struct {
        row_kind_t   kind;
        logic [23:0] size;
        pair_t       px;
        bit          typed;
        report_t     want;
    } row_t;

    logic                             i_clk;
    logic                             i_rst_n;
    logic [hcmd_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             s_axis_tlast;
    logic                             s_axis_tvalid;
    wire                              s_axis_tready;
    wire  [hcmd_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    wire                              m_axis_tvalid;
    logic                             m_axis_tready;
    logic                             i_cfg_we;
    logic [hcmd_pkg::FRAME_W-1:0]     i_cfg_wdata;

    // Predictor state: the frame size register and the running change count.
    logic [23:0] frame_size;
    logic [23:0] changed_tally;
    // Reports still owed by the block, oldest first.
    report_t     frame_reports[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    hue_change_motion_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Hue of one color. Integer division in SystemVerilog truncates toward zero, and the
    // final cast keeps the sum modulo 256, so negative offsets wrap below the base.
    function automatic logic [7:0] pixel_hue(input rgb_t c);
        int hi;
        int lo;
        int num;
        int base;
        hi = c.r;
        lo = c.r;
        if (c.g > hi) hi = c.g;
        if (c.b > hi) hi = c.b;
        if (c.g < lo) lo = c.g;
        if (c.b < lo) lo = c.b;
        if (hi == 0 || hi == lo) begin
            return 8'd0;
        end
        // The red channel wins ties, then green.
        if (hi == c.r) begin
            base = 0;
            num  = 43 * (int'(c.g) - int'(c.b));
        end else if (hi == c.g) begin
            base = 85;
            num  = 43 * (int'(c.b) - int'(c.r));
        end else begin
            base = 171;
            num  = 43 * (int'(c.r) - int'(c.g));
        end
        return 8'(base + num / (hi - lo));
    endfunction

    // Advances the change count by one pixel pair and returns the report that the frame
    // would give if this pixel ended it. The count saturates and is cleared on tlast.
    function automatic report_t advance_tally(input pair_t p);
        logic [7:0] hue_prev;
        logic [7:0] hue_cur;
        logic [7:0] gap;
        report_t    r;
        hue_prev = pixel_hue(p.prev);
        hue_cur  = pixel_hue(p.cur);
        // Plain absolute difference: hues near 0 and near 255 count as far apart.
        gap = (hue_cur > hue_prev) ? hue_cur - hue_prev : hue_prev - hue_cur;
        if (p.sel && gap > HUE_LIMIT && changed_tally != TALLY_MAX) begin
            changed_tally++;
        end
        r.count  = changed_tally;
        r.motion = (64'(changed_tally) * MOTION_SCALE) > 64'(frame_size);
        if (p.last) begin
            changed_tally = '0;
        end
        return r;
    endfunction

    function automatic row_t px_row(input logic [7:0] pr, input logic [7:0] pg,
                                    input logic [7:0] pb, input logic [7:0] cr,
                                    input logic [7:0] cg, input logic [7:0] cb,
                                    input logic sel, input logic last);
        row_t row;
        row.kind  = ROW_PIXEL;
        row.size  = '0;
        row.px    = {cb, cg, cr, pb, pg, pr, sel, last};
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic row_t size_row(input logic [23:0] v);
        row_t row;
        row       = px_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        row.kind  = ROW_FRAME_SIZE;
        row.size  = v;
        return row;
    endfunction

    function automatic row_t with_report(input row_t row, input logic motion,
                                         input logic [23:0] count);
        row_t r;
        r        = row;
        r.typed  = 1'b1;
        r.want   = {count, motion};
        return r;
    endfunction

    // Colors are mostly random, with gray pixels and tied largest channels mixed in.
    function automatic rgb_t rand_rgb();
        rgb_t c;
        c = 24'($urandom);
        case ($urandom_range(7))
            0: begin
                c.g = c.r;
                c.b = c.r;
            end
            1: c.g = c.r;
            2: c.b = c.g;
            3: c.b = c.r;
            default: ;
        endcase
        return c;
    endfunction

    // A still pixel, a pixel with a little noise, or an unrelated color.
    function automatic pair_t rand_pair(input logic last);
        pair_t p;
        p.prev = rand_rgb();
        case ($urandom_range(9))
            0, 1, 2: p.cur = p.prev;
            3, 4:    p.cur = p.prev ^ (24'($urandom) & 24'h070707);
            default: p.cur = rand_rgb();
        endcase
        p.sel  = ($urandom_range(9) != 0);
        p.last = last;
        return p;
    endfunction

    task automatic check_report(input logic [hcmd_pkg::OUT_DATA_W-1:0] word);
        report_t want;
        if (frame_reports.size() == 0) begin
            if (errors < SHOWN_ERRORS) begin
                $display("tb: report %h arrived with none expected", word);
            end
            errors++;
        end else begin
            want = frame_reports.pop_front();
            if (word[0] !== want.motion || word[24:1] !== want.count) begin
                if (errors < SHOWN_ERRORS) begin
                    $display("tb: report mismatch: motion %b count %0d, expected %b %0d",
                             word[0], word[24:1], want.motion, want.count);
                end
                errors++;
            end
        end
    endtask

    // Output side: every accepted report is checked against the oldest one owed. The
    // ready line is drawn afresh each cycle from the current stall rate.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_report(m_axis_tdata);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one pixel request, with random idle cycles ahead of it, and returns at the
    // edge where it is accepted. tvalid stays high when the next request follows at once.
    task automatic drive_pixel(input pair_t p, input bit typed, input report_t want);
        report_t got;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.cur, p.prev};
        s_axis_tuser  <= p.sel;
        s_axis_tlast  <= p.last;
        do @(posedge i_clk); while (!s_axis_tready);
        got = advance_tally(p);
        if (p.last) begin
            frame_reports.push_back(typed ? want : got);
        end
    endtask

    // The frame size is written only when the block is idle. Every phase ends on a tlast
    // pixel, so once its report is in nothing is left inside; the extra cycles are margin.
    task automatic write_frame_size(input logic [23:0] v);
        s_axis_tvalid <= 1'b0;
        while (frame_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_size = v;
    endtask

    initial begin
        row_t        directed[$];
        int          left;
        int          flen;
        int          drain;
        logic [23:0] size_pick;

        i_rst_n       <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        s_axis_tvalid <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        frame_size    = SIZE_AT_RESET;
        changed_tally = '0;

        // Single-pixel frames right after reset: a black pair reports nothing, a red to
        // green change counts once, and the same change on an unselected last pixel still
        // yields a report but adds nothing.
        directed.push_back(with_report(px_row(0, 0, 0, 0, 0, 0, 1, 1), 1'b0, 24'd0));
        directed.push_back(with_report(px_row(255, 0, 0, 0, 255, 0, 1, 1), 1'b0, 24'd1));
        directed.push_back(with_report(px_row(255, 0, 0, 0, 255, 0, 0, 1), 1'b0, 24'd0));
        // One frame of hue corner cases. A step of exactly 16 does not count and 17 does.
        directed.push_back(px_row(255, 0, 0, 255, 95, 0, 1, 0));
        directed.push_back(px_row(255, 0, 0, 255, 101, 0, 1, 0));
        // Hue 250 against hue 5 is far apart, since there is no wrap.
        directed.push_back(px_row(255, 0, 36, 255, 30, 0, 1, 0));
        // A red-green tie against a green-blue tie.
        directed.push_back(px_row(255, 255, 0, 0, 255, 255, 1, 0));
        // Gray against pure blue, then white against a negative red offset.
        directed.push_back(px_row(128, 128, 128, 0, 0, 255, 1, 0));
        directed.push_back(px_row(255, 255, 255, 255, 0, 255, 1, 0));
        directed.push_back(px_row(1, 0, 0, 0, 0, 1, 1, 0));
        directed.push_back(px_row(255, 0, 1, 0, 1, 255, 1, 1));
        // A frame size of zero: any nonzero count raises motion.
        directed.push_back(size_row(24'd0));
        directed.push_back(with_report(px_row(0, 0, 0, 0, 0, 0, 1, 1), 1'b0, 24'd0));
        directed.push_back(with_report(px_row(255, 0, 0, 0, 255, 0, 1, 1), 1'b1, 24'd1));
        // The largest frame size keeps motion low.
        directed.push_back(size_row(24'hFFFFFF));
        directed.push_back(px_row(0, 0, 255, 255, 0, 0, 1, 0));
        directed.push_back(px_row(0, 255, 0, 0, 0, 255, 1, 0));
        directed.push_back(with_report(px_row(255, 0, 0, 0, 255, 0, 1, 1), 1'b0, 24'd3));
        // A frame size of one: a single change is enough.
        directed.push_back(size_row(24'd1));
        directed.push_back(with_report(px_row(0, 255, 0, 0, 0, 255, 1, 1), 1'b1, 24'd1));
        directed.push_back(size_row(SIZE_AT_RESET));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_FRAME_SIZE) begin
                write_frame_size(directed[k].size);
            end else begin
                drive_pixel(directed[k].px, directed[k].typed, directed[k].want);
            end
        end

        // Random frames in three idle patterns: a slow receiver, a slow sender, and none.
        // Each pattern runs under three frame sizes, chosen so motion both trips and not.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int ph = 0; ph < 3; ph++) begin
                case (mode * 3 + ph)
                    0:       size_pick = 24'd1;
                    2:       size_pick = 24'hFFFFFF;
                    3:       size_pick = 24'd0;
                    5:       size_pick = 24'd500;
                    7:       size_pick = SIZE_AT_RESET;
                    default: size_pick = 24'($urandom_range(1, 2000));
                endcase
                write_frame_size(size_pick);
                // Mostly short frames, now and then a longer one; the phase closes a frame.
                left = PHASE_ITEMS;
                while (left > 0) begin
                    flen = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 16);
                    if (flen > left) flen = left;
                    for (int i = 0; i < flen; i++) begin
                        drive_pixel(rand_pair(i == flen - 1), 1'b0, '0);
                    end
                    left -= flen;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (frame_reports.size() != 0 && drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        if (frame_reports.size() != 0) begin
            $display("tb: %0d frame reports never arrived", frame_reports.size());
            errors += frame_reports.size();
        end
        // Any stray report in this window is flagged by the output checker.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // A run that has not finished by this time ends as a failure.
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/hcmd_pkg.sv
rtl/core/hcmd_queue.sv
rtl/core/hcmd_front.sv
rtl/core/hcmd_back.sv
rtl/core/hue_change_motion_detector.sv
verif/tb.sv
